>>> rtl/midi_clock_splitter_scheduler_top_defines.svh
// Assertion macros shared by the scheduler RTL.
// Every macro samples on clk and is disabled while rst is high.
`ifndef MIDI_CLOCK_SPLITTER_SCHEDULER_TOP_DEFINES_SVH
`define MIDI_CLOCK_SPLITTER_SCHEDULER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCSS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MCSS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mcss_pkg.sv
// Shared types, command codes and constants for the MIDI clock splitter scheduler.
// No dependencies; used by the FIFO and the top level.
`timescale 1ns / 1ps

package mcss_pkg;

  localparam int TIME_W    = 48;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;
  localparam int ENTRY_W   = TIME_W + 3;

  // Request commands.
  localparam logic [2:0] CMD_TICK      = 3'd0;
  localparam logic [2:0] CMD_RX_BYTE   = 3'd1;
  localparam logic [2:0] CMD_SYNC_EDGE = 3'd2;
  localparam logic [2:0] CMD_POP_CLOCK = 3'd3;
  localparam logic [2:0] CMD_POP_BYTE  = 3'd4;
  localparam logic [2:0] CMD_ARM       = 3'd5;
  localparam logic [2:0] CMD_SEND      = 3'd6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_TIME   = 1'b1;

  localparam logic [15:0] PULSE_WIDTH_RST = 16'd5000;
  localparam logic [11:0] BYTE_TIME_RST   = 12'd320;

  // Real-time status bytes.
  localparam logic [7:0] ST_CLOCK    = 8'hF8;
  localparam logic [7:0] ST_START    = 8'hFA;
  localparam logic [7:0] ST_CONTINUE = 8'hFB;
  localparam logic [7:0] ST_STOP     = 8'hFC;

  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_RESUME = 2'd2;
  localparam logic [1:0] KIND_STOP   = 2'd3;

  localparam logic PORT_MIDI = 1'b0;
  localparam logic PORT_SYNC = 1'b1;

  typedef struct packed {
    logic [2:0]        command;
    logic [7:0]        data_byte;
    logic              port;
    logic [1:0]        pulse_kind;
    logic [TIME_W-1:0] deadline;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic              read_port;
    logic [1:0]        read_kind;
    logic [TIME_W-1:0] read_time;
    logic [7:0]        read_byte;
    logic              tx_valid;
    logic [7:0]        tx_byte;
    logic              sync_level;
  } rsp_t;

  // Handshake outcome of one FIFO access.
  typedef struct packed {
    logic push_ok;
    logic pop_ok;
  } fifo_stat_t;

  // True when time a has reached time b, judged by the signed 48-bit difference.
  function automatic logic reached(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] diff;
    diff = a - b;
    return ~diff[TIME_W-1];
  endfunction

  function automatic logic [7:0] status_byte(input logic [1:0] kind);
    logic [7:0] st;
    case (kind)
      KIND_TICK:   st = ST_CLOCK;
      KIND_START:  st = ST_START;
      KIND_RESUME: st = ST_CONTINUE;
      KIND_STOP:   st = ST_STOP;
      default:     st = ST_CLOCK;
    endcase
    return st;
  endfunction

endpackage

>>> rtl/mcss_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module mcss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/mcss_fifo.sv
// Drop-on-full FIFO: pointer control around one mcss_ram instance.
// Depends on mcss_pkg, mcss_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "midi_clock_splitter_scheduler_top_defines.svh"

module mcss_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                pop,
  input  logic [WIDTH-1:0]    wdata,
  output mcss_pkg::fifo_stat_t stat,
  output logic [WIDTH-1:0]    rdata
);
  import mcss_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  // Index plus a lap bit, so full and empty differ without a count.
  logic [AW-1:0] wr_idx;
  logic          wr_lap;
  logic [AW-1:0] rd_idx;
  logic          rd_lap;
  logic          empty;
  logic          full;

  assign empty        = (wr_idx == rd_idx) && (wr_lap == rd_lap);
  assign full         = (wr_idx == rd_idx) && (wr_lap != rd_lap);
  assign stat.push_ok = push && !full;
  assign stat.pop_ok  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      wr_lap <= 1'b0;
      rd_idx <= '0;
      rd_lap <= 1'b0;
    end else begin
      if (stat.push_ok) begin
        if (wr_idx == LAST) begin
          wr_idx <= '0;
          wr_lap <= ~wr_lap;
        end else begin
          wr_idx <= wr_idx + AW'(1);
        end
      end
      if (stat.pop_ok) begin
        if (rd_idx == LAST) begin
          rd_idx <= '0;
          rd_lap <= ~rd_lap;
        end else begin
          rd_idx <= rd_idx + AW'(1);
        end
      end
    end
  end

  mcss_ram #(
    .WIDTH(WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (stat.push_ok),
    .waddr(wr_idx),
    .wdata(wdata),
    .re   (stat.pop_ok),
    .raddr(rd_idx),
    .rdata(rdata)
  );

  `MCSS_ASSERT_IMP(a_not_full_and_empty, full, !empty, "FIFO reports full and empty at once")
  `MCSS_ASSERT_NEXT(a_push_not_empty, stat.push_ok && !pop, !empty, "FIFO empty after a push")
  `MCSS_ASSERT_NEXT(a_pop_not_full, stat.pop_ok && !push, !full, "FIFO full after a pop")

endmodule

>>> rtl/midi_clock_splitter_scheduler_top.sv
// MIDI real-time clock splitter and output scheduler, top level.
// Depends on mcss_pkg and mcss_fifo (which holds mcss_ram).
`timescale 1ns / 1ps

// One request is accepted per clock cycle, and its response appears in the cycle after
// acceptance: all state (time counter, FIFO pointers, armed deadlines, sync pin, pacing)
// is updated at the accepting edge, and the response comes from a single result register
// together with the registered read port of the FIFO memories. A request is held off only
// while a finished response waits on a stalled output. The FIFOs need no clearing after
// reset. Configuration writes take effect at the next edge and are expected while idle.
module midi_clock_splitter_scheduler_top #(
  parameter int CLOCK_FIFO_DEPTH = 16,
  parameter int BYTE_FIFO_DEPTH  = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  mcss_pkg::req_t                     req,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output mcss_pkg::rsp_t                     rsp,
  input  logic                               cfg_we,
  input  logic [mcss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mcss_pkg::CFG_W-1:0]         cfg_wdata
);
  import mcss_pkg::*;

  logic [15:0]       pulse_width_us;
  logic [11:0]       byte_time_us;

  logic [TIME_W-1:0] now_time;
  logic [TIME_W-1:0] now_time_next;
  logic              midi_armed;
  logic              midi_armed_next;
  logic [1:0]        midi_armed_kind;
  logic [1:0]        midi_armed_kind_next;
  logic [TIME_W-1:0] midi_due_time;
  logic [TIME_W-1:0] midi_due_time_next;
  logic              sync_armed;
  logic              sync_armed_next;
  logic [TIME_W-1:0] sync_due_time;
  logic [TIME_W-1:0] sync_due_time_next;
  logic              sync_high;
  logic              sync_high_next;
  logic [TIME_W-1:0] sync_fall_time;
  logic [TIME_W-1:0] sync_fall_time_next;
  logic [TIME_W-1:0] next_send_time;
  logic [TIME_W-1:0] next_send_time_next;

  logic              accept;
  logic              sync_rise;

  logic              clock_push;
  logic              clock_pop;
  logic [ENTRY_W-1:0] clock_wdata;
  logic [ENTRY_W-1:0] clock_rdata;
  fifo_stat_t        clock_stat;
  logic [1:0]        rx_kind;
  logic              rx_is_clock;

  logic              byte_push;
  logic              byte_pop;
  logic [7:0]        byte_rdata;
  fifo_stat_t        byte_stat;

  // Result register; popped data is taken from the FIFO read registers.
  logic              res_ok;
  logic              res_ok_next;
  logic              res_tx_valid;
  logic              res_tx_valid_next;
  logic [7:0]        res_tx_byte;
  logic [7:0]        res_tx_byte_next;
  logic              res_sync_level;
  logic              res_sel_clock;
  logic              res_sel_byte;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  always_comb begin
    rx_is_clock = 1'b1;
    case (req.data_byte)
      ST_CLOCK:    rx_kind = KIND_TICK;
      ST_START:    rx_kind = KIND_START;
      ST_CONTINUE: rx_kind = KIND_RESUME;
      ST_STOP:     rx_kind = KIND_STOP;
      default: begin
        rx_kind     = KIND_TICK;
        rx_is_clock = 1'b0;
      end
    endcase
  end

  always_comb begin
    clock_push  = 1'b0;
    clock_pop   = 1'b0;
    byte_push   = 1'b0;
    byte_pop    = 1'b0;
    clock_wdata = {PORT_MIDI, rx_kind, now_time};
    if (accept) begin
      case (req.command)
        CMD_RX_BYTE: begin
          clock_push = rx_is_clock;
          byte_push  = !rx_is_clock;
        end
        CMD_SYNC_EDGE: begin
          clock_push  = 1'b1;
          clock_wdata = {PORT_SYNC, KIND_TICK, now_time};
        end
        CMD_POP_CLOCK: clock_pop = 1'b1;
        CMD_POP_BYTE:  byte_pop  = 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    now_time_next        = now_time;
    midi_armed_next      = midi_armed;
    midi_armed_kind_next = midi_armed_kind;
    midi_due_time_next   = midi_due_time;
    sync_armed_next      = sync_armed;
    sync_due_time_next   = sync_due_time;
    sync_high_next       = sync_high;
    sync_fall_time_next  = sync_fall_time;
    next_send_time_next  = next_send_time;
    res_ok_next          = 1'b0;
    res_tx_valid_next    = 1'b0;
    res_tx_byte_next     = 8'h00;
    sync_rise            = 1'b0;
    case (req.command)
      CMD_TICK: begin
        now_time_next = now_time + TIME_W'(1);
        res_ok_next   = 1'b1;
        if (midi_armed && reached(now_time_next, midi_due_time)) begin
          res_tx_valid_next = 1'b1;
          res_tx_byte_next  = status_byte(midi_armed_kind);
          midi_armed_next   = 1'b0;
        end
        sync_rise = sync_armed && reached(now_time_next, sync_due_time);
        if (sync_rise) begin
          sync_armed_next     = 1'b0;
          sync_fall_time_next = now_time_next + TIME_W'(pulse_width_us);
          // A rise falls on the same tick only when the width is zero.
          sync_high_next      = (pulse_width_us != 16'd0);
        end else if (sync_high && reached(now_time_next, sync_fall_time)) begin
          sync_high_next = 1'b0;
        end
      end
      CMD_RX_BYTE:   res_ok_next = clock_stat.push_ok || byte_stat.push_ok;
      CMD_SYNC_EDGE: res_ok_next = clock_stat.push_ok;
      CMD_POP_CLOCK: res_ok_next = clock_stat.pop_ok;
      CMD_POP_BYTE:  res_ok_next = byte_stat.pop_ok;
      CMD_ARM: begin
        if (req.port == PORT_MIDI) begin
          if (!midi_armed) begin
            midi_armed_next      = 1'b1;
            midi_armed_kind_next = req.pulse_kind;
            midi_due_time_next   = req.deadline;
            res_ok_next          = 1'b1;
          end
        end else if (!sync_armed) begin
          sync_armed_next    = 1'b1;
          sync_due_time_next = req.deadline;
          res_ok_next        = 1'b1;
        end
      end
      CMD_SEND: begin
        if (reached(now_time, next_send_time)) begin
          res_ok_next         = 1'b1;
          res_tx_valid_next   = 1'b1;
          res_tx_byte_next    = req.data_byte;
          next_send_time_next = now_time + TIME_W'(byte_time_us);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_width_us  <= PULSE_WIDTH_RST;
      byte_time_us    <= BYTE_TIME_RST;
      now_time        <= '0;
      midi_armed      <= 1'b0;
      midi_armed_kind <= KIND_TICK;
      midi_due_time   <= '0;
      sync_armed      <= 1'b0;
      sync_due_time   <= '0;
      sync_high       <= 1'b0;
      sync_fall_time  <= '0;
      next_send_time  <= '0;
      rsp_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PULSE_WIDTH: pulse_width_us <= cfg_wdata;
          CFG_BYTE_TIME:   byte_time_us   <= cfg_wdata[11:0];
          default: ;
        endcase
      end
      if (accept) begin
        now_time        <= now_time_next;
        midi_armed      <= midi_armed_next;
        midi_armed_kind <= midi_armed_kind_next;
        midi_due_time   <= midi_due_time_next;
        sync_armed      <= sync_armed_next;
        sync_due_time   <= sync_due_time_next;
        sync_high       <= sync_high_next;
        sync_fall_time  <= sync_fall_time_next;
        next_send_time  <= next_send_time_next;
        rsp_valid       <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_ok         <= res_ok_next;
      res_tx_valid   <= res_tx_valid_next;
      res_tx_byte    <= res_tx_byte_next;
      res_sync_level <= sync_high_next;
      res_sel_clock  <= clock_stat.pop_ok;
      res_sel_byte   <= byte_stat.pop_ok;
    end
  end

  mcss_fifo #(
    .WIDTH(ENTRY_W),
    .DEPTH(CLOCK_FIFO_DEPTH)
  ) u_clock_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (clock_push),
    .pop  (clock_pop),
    .wdata(clock_wdata),
    .stat (clock_stat),
    .rdata(clock_rdata)
  );

  mcss_fifo #(
    .WIDTH(8),
    .DEPTH(BYTE_FIFO_DEPTH)
  ) u_byte_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (byte_push),
    .pop  (byte_pop),
    .wdata(req.data_byte),
    .stat (byte_stat),
    .rdata(byte_rdata)
  );

  always_comb begin
    rsp.ok         = res_ok;
    rsp.read_port  = res_sel_clock ? clock_rdata[ENTRY_W-1] : 1'b0;
    rsp.read_kind  = res_sel_clock ? clock_rdata[ENTRY_W-2 -: 2] : 2'b00;
    rsp.read_time  = res_sel_clock ? clock_rdata[TIME_W-1:0] : '0;
    rsp.read_byte  = res_sel_byte ? byte_rdata : 8'h00;
    rsp.tx_valid   = res_tx_valid;
    rsp.tx_byte    = res_tx_byte;
    rsp.sync_level = res_sync_level;
  end

endmodule
